// ----- hw/rtl/i2cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared codes for the I2C bit-level master core: commands, phases,
// register indexes and stream field layouts.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes carried in the action field
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_ACK   = 3'd4,
        ACT_READ  = 3'd5
    } t_action;

    // Line sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ST_A  = 4'd1,
        PH_ST_B  = 4'd2,
        PH_ST_C  = 4'd3,
        PH_SP_A  = 4'd4,
        PH_SP_B  = 4'd5,
        PH_SP_C  = 4'd6,
        PH_WR_LO = 4'd7,
        PH_WR_HI = 4'd8,
        PH_AK_LO = 4'd9,
        PH_AK_WT = 4'd10,
        PH_RD_LO = 4'd11,
        PH_RD_HI = 4'd12,
        PH_MA_LO = 4'd13,
        PH_MA_HI = 4'd14
    } t_phase;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_LIMIT   = 1'b1;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd200;
    localparam logic [15:0] ACK_LIMIT_RESET   = 16'd1000;

    // Input request fields, packed from bit 0
    typedef struct packed {
        logic [2:0] pad;
        logic       sda_level;
        logic       send_nack;
        logic [7:0] tx_byte;
        logic [2:0] action;
    } t_in_data;

    // Result fields, packed from bit 0
    typedef struct packed {
        logic [1:0] pad;
        logic       ack_timed_out;
        logic       ack_seen;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_drive;
    } t_out_data;

endpackage

// ----- hw/rtl/i2c_bit_level_master_core.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core
// I2C master line sequencer stepped once per accepted request (one tick).
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | s_axis_tdata[15:0]
//  m_axis    | out       | m_axis_tvalid/tready       | m_axis_tdata[15:0]
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One request is one line tick and yields one result on the cycle after it
//  is accepted: the step is computed from the phase registers and the
//  request and lands in the output register, so a request is taken every
//  cycle while the result side keeps up. The single output register sets the
//  rate: a stalled result blocks new requests until it is taken.
//  Reset (synchronous, active low) returns the sequencer to idle with both
//  lines released and loads the register defaults (200 and 1000 ticks).
//  Configuration writes are taken in any cycle.
//
module i2c_bit_level_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: action[2:0], tx_byte[10:3], send_nack[11], sda_level[12], zeros
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // result: scl_drive[0], sda_drive[1], busy_res[2], done_res[3],
    //         rx_byte[11:4], ack_seen[12], ack_timed_out[13], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [7:0]  r_half_period;
    logic [15:0] r_ack_limit;

    // Sequencer state
    i2cbm_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift_reg, n_shift_reg;
    logic [7:0]  r_tick_count, n_tick_count;
    logic [15:0] r_wait_count, n_wait_count;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_nack_pending, n_nack_pending;

    // Output register
    logic                 r_out_valid;
    i2cbm_pkg::t_out_data r_out, n_out;

    i2cbm_pkg::t_in_data  in_req;
    logic                 s_accept;
    logic [16:0]          wait_next;
    logic                 finish;

    assign in_req        = i2cbm_pkg::t_in_data'(s_axis_tdata);
    // Take a new request whenever the output register frees up this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out);
    assign o_cfg_ready   = 1'b1;
    assign wait_next     = {1'b0, r_wait_count} + 17'd1;

    // One tick of the line sequencer
    always_comb begin
        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_shift_reg    = r_shift_reg;
        n_tick_count   = r_tick_count;
        n_wait_count   = r_wait_count;
        n_scl          = r_scl;
        n_sda          = r_sda;
        n_nack_pending = r_nack_pending;
        finish         = 1'b0;
        n_out          = '0;

        if (r_phase == i2cbm_pkg::PH_IDLE) begin
            // Enter the first phase of a command; this tick counts as held
            unique case (in_req.action)
                i2cbm_pkg::ACT_START: begin
                    n_phase = i2cbm_pkg::PH_ST_A;
                    n_scl = 1'b1; n_sda = 1'b1; n_tick_count = 8'd1;
                end
                i2cbm_pkg::ACT_STOP: begin
                    n_phase = i2cbm_pkg::PH_SP_A;
                    n_scl = 1'b0; n_sda = 1'b0; n_tick_count = 8'd1;
                end
                i2cbm_pkg::ACT_WRITE: begin
                    n_shift_reg = in_req.tx_byte;
                    n_bit_count = 3'd0;
                    n_phase = i2cbm_pkg::PH_WR_LO;
                    n_scl = 1'b0; n_sda = in_req.tx_byte[7]; n_tick_count = 8'd1;
                end
                i2cbm_pkg::ACT_ACK: begin
                    n_wait_count = 16'd0;
                    n_phase = i2cbm_pkg::PH_AK_LO;
                    n_scl = 1'b0; n_sda = 1'b1; n_tick_count = 8'd1;
                end
                i2cbm_pkg::ACT_READ: begin
                    n_shift_reg = 8'd0;
                    n_bit_count = 3'd0;
                    n_nack_pending = in_req.send_nack;
                    n_phase = i2cbm_pkg::PH_RD_LO;
                    n_scl = 1'b0; n_sda = 1'b1; n_tick_count = 8'd1;
                end
                default: ;
            endcase
        end else if (r_phase == i2cbm_pkg::PH_AK_WT) begin
            // Sample SDA every tick until acknowledged or out of time
            if (!in_req.sda_level) begin
                n_out.ack_seen = 1'b1;
                finish = 1'b1;
            end else if (wait_next >= {1'b0, r_ack_limit}) begin
                n_out.ack_timed_out = 1'b1;
                finish = 1'b1;
            end else begin
                n_wait_count = wait_next[15:0];
            end
            if (finish) begin
                n_scl = 1'b0;
                n_sda = 1'b1;
            end
        end else if (r_tick_count < r_half_period) begin
            n_tick_count = r_tick_count + 8'd1;
        end else begin
            n_tick_count = 8'd1;
            unique case (r_phase)
                i2cbm_pkg::PH_ST_A: begin
                    n_phase = i2cbm_pkg::PH_ST_B; n_scl = 1'b1; n_sda = 1'b0;
                end
                i2cbm_pkg::PH_ST_B: begin
                    n_phase = i2cbm_pkg::PH_ST_C; n_scl = 1'b0; n_sda = 1'b0;
                end
                i2cbm_pkg::PH_ST_C: finish = 1'b1;
                i2cbm_pkg::PH_SP_A: begin
                    n_phase = i2cbm_pkg::PH_SP_B; n_scl = 1'b1; n_sda = 1'b0;
                end
                i2cbm_pkg::PH_SP_B: begin
                    n_phase = i2cbm_pkg::PH_SP_C; n_scl = 1'b1; n_sda = 1'b1;
                end
                i2cbm_pkg::PH_SP_C: finish = 1'b1;
                i2cbm_pkg::PH_WR_LO: begin
                    n_phase = i2cbm_pkg::PH_WR_HI; n_scl = 1'b1;
                end
                i2cbm_pkg::PH_WR_HI: begin
                    if (r_bit_count == 3'd7) begin
                        // Last bit: drop SCL, leave SDA where it is
                        n_scl = 1'b0;
                        finish = 1'b1;
                    end else begin
                        n_bit_count = r_bit_count + 3'd1;
                        n_shift_reg = {r_shift_reg[6:0], 1'b0};
                        n_phase = i2cbm_pkg::PH_WR_LO;
                        n_scl = 1'b0; n_sda = r_shift_reg[6];
                    end
                end
                i2cbm_pkg::PH_AK_LO: begin
                    n_wait_count = 16'd0;
                    n_phase = i2cbm_pkg::PH_AK_WT; n_scl = 1'b1; n_sda = 1'b1;
                end
                i2cbm_pkg::PH_RD_LO: begin
                    n_phase = i2cbm_pkg::PH_RD_HI; n_scl = 1'b1; n_sda = 1'b1;
                end
                i2cbm_pkg::PH_RD_HI: begin
                    // Shift in the bit at the end of its high phase
                    n_shift_reg = {r_shift_reg[6:0], in_req.sda_level};
                    if (r_bit_count == 3'd7) begin
                        n_phase = i2cbm_pkg::PH_MA_LO;
                        n_scl = 1'b0; n_sda = r_nack_pending;
                    end else begin
                        n_bit_count = r_bit_count + 3'd1;
                        n_phase = i2cbm_pkg::PH_RD_LO;
                        n_scl = 1'b0; n_sda = 1'b1;
                    end
                end
                i2cbm_pkg::PH_MA_LO: begin
                    n_phase = i2cbm_pkg::PH_MA_HI; n_scl = 1'b1; n_sda = r_nack_pending;
                end
                i2cbm_pkg::PH_MA_HI: begin
                    n_out.rx_byte = r_shift_reg;
                    n_scl = 1'b0; n_sda = 1'b1;
                    finish = 1'b1;
                end
                default: begin
                    // Unused phase code: drop back to idle quietly
                    n_phase = i2cbm_pkg::PH_IDLE;
                    n_tick_count = 8'd0;
                end
            endcase
        end

        if (finish) begin
            n_phase = i2cbm_pkg::PH_IDLE;
            n_tick_count = 8'd0;
            n_out.done_res = 1'b1;
        end

        n_out.scl_drive = n_scl;
        n_out.sda_drive = n_sda;
        n_out.busy_res  = (n_phase != i2cbm_pkg::PH_IDLE);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cbm_pkg::HALF_PERIOD_RESET;
            r_ack_limit   <= i2cbm_pkg::ACK_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == i2cbm_pkg::CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data[7:0];
            end
            if (i_cfg_index == i2cbm_pkg::CFG_ACK_LIMIT) begin
                r_ack_limit <= i_cfg_data;
            end
        end
    end

    // Sequencer state and output valid; advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= i2cbm_pkg::PH_IDLE;
            r_bit_count    <= 3'd0;
            r_shift_reg    <= 8'd0;
            r_tick_count   <= 8'd0;
            r_wait_count   <= 16'd0;
            r_scl          <= 1'b1;
            r_sda          <= 1'b1;
            r_nack_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_shift_reg    <= n_shift_reg;
                r_tick_count   <= n_tick_count;
                r_wait_count   <= n_wait_count;
                r_scl          <= n_scl;
                r_sda          <= n_sda;
                r_nack_pending <= n_nack_pending;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_accept |=> $stable(r_phase) && $stable(r_tick_count))
        else $error("sequencer state moved without a request");

    a_idle_tick_zero: assert property (@(posedge i_clk)
        (r_phase == i2cbm_pkg::PH_IDLE) |-> (r_tick_count == 8'd0))
        else $error("tick count not cleared in idle");

    a_busy_tick_nonzero: assert property (@(posedge i_clk)
        (r_phase != i2cbm_pkg::PH_IDLE) |-> (r_tick_count != 8'd0))
        else $error("busy phase with zero tick count");

    a_write_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_phase == i2cbm_pkg::PH_IDLE
            && in_req.action == i2cbm_pkg::ACT_WRITE)
        |=> (r_shift_reg == $past(in_req.tx_byte)) && (r_phase == i2cbm_pkg::PH_WR_LO))
        else $error("write command did not load the shift register");
`endif

endmodule
